FILE: rtl/core/ucb1_pkg.sv
// Package for the UCB1 action-value table core.
// Holds command codes, table sizes and the fixed-point constants.
// No dependencies.
package ucb1_pkg;
  localparam int NUM_STATES_DEF     = 64;
  localparam int NUM_UNIT_TYPES_DEF = 4;
  localparam int NUM_ACTIONS_DEF    = 16;

  localparam logic [2:0] CMD_REGISTER = 3'd0;
  localparam logic [2:0] CMD_SEED     = 3'd1;
  localparam logic [2:0] CMD_UPDATE   = 3'd2;
  localparam logic [2:0] CMD_SELECT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  localparam logic [15:0] BONUS_RESET   = 16'd256;
  localparam logic [15:0] LN2_Q16       = 16'd45426;
  localparam logic [23:0] VISIT_MAX     = 24'hFFFFFF;
  localparam logic signed [63:0] UNTRIED_SCORE = 64'sd65536000000;
endpackage

FILE: rtl/core/ucb1_action_value_table_core.sv
// Top level of the UCB1 action-value table core.
// Uses ucb1_pkg and ucb1_divider.
//
// Usage: one command transaction enters on the in_ channel (valid/ready) and
// exactly one result transaction leaves on the out_ channel. The block works
// on one command at a time and drops in_ready while busy. The result sits in
// an output register; the next command is taken while it waits.
// Register, seed and unused codes go straight to the result; update of an
// existing entry runs one 64-step division, and clear runs the clearing
// pass. Select first takes the log of N, then runs a 64-step division and
// a square root per valid tried slot, scores each valid untried slot
// directly and skips masked slots. The divider and the square-root stepper
// are the limiting units. A new command is taken the cycle after the
// result is loaded into the output register.
// Reset: the bonus register returns to 1.0, and a clearing pass over all
// NUM_STATES*NUM_UNIT_TYPES units (256 by default) sweeps the present
// bits and unit counts; clear commands run the same pass. No command is
// taken during the pass. If the receiver stalls, the block finishes the
// current command and holds at the output until the waiting result is taken.
module ucb1_action_value_table_core #(
  parameter int NUM_STATES     = ucb1_pkg::NUM_STATES_DEF,
  parameter int NUM_UNIT_TYPES = ucb1_pkg::NUM_UNIT_TYPES_DEF,
  parameter int NUM_ACTIONS    = ucb1_pkg::NUM_ACTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_tree_state,
  input  logic [1:0]  in_unit_type,
  input  logic [3:0]  in_action,
  input  logic signed [31:0] in_sample_value,
  input  logic [15:0] in_valid_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_selected_action,
  output logic        out_any_valid
);
  localparam int UDEPTH = NUM_STATES * NUM_UNIT_TYPES;
  localparam int AW     = $clog2(NUM_ACTIONS);
  localparam int UW     = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
  localparam int EW     = UW + AW;
  localparam int PW     = 1 << AW;
  localparam int EDEPTH = UDEPTH * PW;
  localparam int SLOTS  = (NUM_ACTIONS < 16) ? NUM_ACTIONS : 16;
  localparam logic [15:0] LN2_W = ucb1_pkg::LN2_Q16;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_EXEC = 5'd3;
  localparam logic [4:0] S_DIVW = 5'd4;
  localparam logic [4:0] S_OUT  = 5'd5;
  localparam logic [4:0] S_LOGA = 5'd6;
  localparam logic [4:0] S_LOGB = 5'd7;
  localparam logic [4:0] S_LN   = 5'd8;
  localparam logic [4:0] S_SL   = 5'd9;
  localparam logic [4:0] S_SRD  = 5'd10;
  localparam logic [4:0] S_SEV  = 5'd11;
  localparam logic [4:0] S_SDIV = 5'd12;
  localparam logic [4:0] S_SQ   = 5'd13;
  localparam logic [4:0] S_TERM = 5'd14;
  localparam logic [4:0] S_CMP  = 5'd15;
  localparam logic [4:0] S_UPW  = 5'd16;
  localparam logic [4:0] S_MULA = 5'd17;
  localparam logic [4:0] S_MULB = 5'd18;

  // Memories. Present bits are kept as one row of action slots per unit.
  logic [PW-1:0]   pres_mem [UDEPTH];
  logic [31:0]     mean_mem [EDEPTH];
  logic [23:0]     vis_mem  [EDEPTH];
  logic [31:0]     unit_mem [UDEPTH];

  logic [4:0]  state_r, state_nxt;
  logic [15:0] bonus_r;
  logic [2:0]  cmd_r;
  logic [UW-1:0] u_r;
  logic [AW-1:0] a_r;
  logic        act_ok_r, unit_ok_r;
  logic signed [31:0] v_r;
  logic [15:0] mask_r;
  logic [UW:0] clr_r;
  logic        clr_cmd_r;
  logic        out_valid_r;
  logic [3:0]  sel_r;
  logic        any_r;

  // Registered memory reads.
  logic [PW-1:0] pres_row_q;
  logic        pres_q;
  logic [AW-1:0] pres_sel;
  logic [31:0] mean_q, unit_q;
  logic [23:0] vis_q;
  logic [EW-1:0] rd_addr;

  // Select working registers.
  logic [4:0]  slot_r;
  logic [4:0]  k_r;
  logic [31:0] m_r;
  logic [4:0]  it_r;
  logic [15:0] frac_r;
  logic [33:0] two_ln_r;
  logic [63:0] x_r, res_r, bit_r;
  logic signed [63:0] score_r, best_score_r;
  logic        found_r;
  logic [3:0]  best_r;
  logic signed [63:0] num_r;

  // Divider.
  logic        div_start;
  logic [63:0] div_dend;
  logic [24:0] div_dsor;
  logic        div_done;
  logic [63:0] div_q;

  ucb1_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dend),
    .divisor(div_dsor), .done(div_done), .quotient(div_q)
  );

  logic in_fire;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // The output register takes a new result when it is empty or being drained.
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  logic [EW-1:0] e_addr;
  assign e_addr = {u_r, a_r};

  // Slot address for select.
  logic [EW-1:0] s_addr;
  assign s_addr = {u_r, AW'(slot_r[3:0])};

  // Present bit of the entry being worked on.
  assign pres_sel = (cmd_r == ucb1_pkg::CMD_SELECT) ? AW'(slot_r[3:0]) : a_r;
  assign pres_q = pres_row_q[pres_sel];

  // Magnitude of the update numerator and rounding.
  logic [63:0] mag, num_abs;
  logic [24:0] den;
  assign den = {1'b0, vis_q} + 25'd1;
  assign num_abs = num_r[63] ? (64'd0 - num_r) : num_r;
  assign mag = num_abs + {40'd0, den[24:1]};

  logic [63:0] sq_full;
  assign sq_full = m_r * m_r;

  logic [63:0] sq_sum;
  assign sq_sum = res_r + bit_r;

  logic [49:0] ln_prod;
  assign ln_prod = {k_r[4:0], frac_r} * {34'd0, LN2_W};

  logic [47:0] term_prod;
  assign term_prod = {16'd0, res_r[31:0]} * {32'd0, bonus_r};

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_dend = x_r;
    div_dsor = {1'b0, vis_q};
    rd_addr = (cmd_r == ucb1_pkg::CMD_SELECT) ? s_addr : e_addr;
    case (state_r)
      S_CLR:  if (clr_r == UDEPTH[UW:0]) state_nxt = clr_cmd_r ? S_OUT : S_IDLE;
      S_IDLE: if (in_fire) state_nxt = S_RD;
      S_RD:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (cmd_r == ucb1_pkg::CMD_CLEAR) state_nxt = S_CLR;
        else if (!unit_ok_r) state_nxt = S_OUT;
        else case (cmd_r)
          ucb1_pkg::CMD_SELECT: state_nxt = (unit_q == 32'd0) ? S_SL : S_LOGA;
          ucb1_pkg::CMD_UPDATE: state_nxt = (act_ok_r && pres_q) ? S_MULA : S_OUT;
          default: state_nxt = S_OUT;
        endcase
      end
      S_MULA: state_nxt = S_MULB;
      S_MULB: begin
        div_start = 1'b1;
        div_dend = mag;
        div_dsor = den;
        state_nxt = S_UPW;
      end
      S_UPW:  if (div_done) state_nxt = S_OUT;
      S_LOGA: if (k_r == 5'd31 || (unit_q >> (k_r + 5'd1)) == 32'd0) state_nxt = S_LOGB;
      S_LOGB: if (it_r == 5'd16) state_nxt = S_LN;
      S_LN:   state_nxt = S_SL;
      S_SL:   begin
        if (slot_r == SLOTS[4:0]) state_nxt = S_OUT;
        else if (mask_r[slot_r[3:0]]) state_nxt = S_SRD;
      end
      S_SRD:  state_nxt = S_SEV;
      S_SEV:  begin
        if (!pres_q || vis_q == 24'd0) state_nxt = S_CMP;
        else begin
          div_start = 1'b1;
          div_dend = {14'd0, two_ln_r, 16'd0};
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: if (div_done) state_nxt = S_SQ;
      S_SQ:   if (bit_r == 64'd0) state_nxt = S_TERM;
      S_TERM: state_nxt = S_CMP;
      S_CMP:  state_nxt = S_SL;
      S_OUT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory ports, including the clearing pass over present rows and unit counts.
  always_ff @(posedge clk) begin
    pres_row_q <= pres_mem[u_r];
    mean_q <= mean_mem[rd_addr];
    vis_q  <= vis_mem[rd_addr];
    unit_q <= unit_mem[u_r];
    if (state_r == S_CLR) begin
      if (clr_r != UDEPTH[UW:0]) begin
        unit_mem[clr_r[UW-1:0]] <= 32'd0;
        pres_mem[clr_r[UW-1:0]] <= '0;
      end
    end else if (state_r == S_EXEC && unit_ok_r && act_ok_r) begin
      if (cmd_r == ucb1_pkg::CMD_SEED && unit_q == 32'd0) unit_mem[u_r] <= 32'd1;
      if (cmd_r == ucb1_pkg::CMD_UPDATE && unit_q != 32'hFFFFFFFF)
        unit_mem[u_r] <= unit_q + 32'd1;
      if (!pres_q && (cmd_r == ucb1_pkg::CMD_REGISTER || cmd_r == ucb1_pkg::CMD_SEED ||
          cmd_r == ucb1_pkg::CMD_UPDATE)) begin
        pres_mem[u_r] <= pres_row_q | (PW'(1) << a_r);
        mean_mem[e_addr] <= (cmd_r == ucb1_pkg::CMD_REGISTER) ? 32'd0 : v_r;
        vis_mem[e_addr]  <= (cmd_r == ucb1_pkg::CMD_REGISTER) ? 24'd0 : 24'd1;
      end
    end else if (state_r == S_UPW && div_done) begin
      mean_mem[e_addr] <= num_r[63] ? (32'd0 - div_q[31:0]) : div_q[31:0];
      if (vis_q != ucb1_pkg::VISIT_MAX) vis_mem[e_addr] <= vis_q + 24'd1;
    end
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      clr_cmd_r <= 1'b0;
      bonus_r <= ucb1_pkg::BONUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) bonus_r <= cfg_wdata;
      if (state_r == S_CLR) begin
        if (clr_r != UDEPTH[UW:0]) clr_r <= clr_r + (UW+1)'(1);
      end else clr_r <= '0;
      if (state_r == S_EXEC && cmd_r == ucb1_pkg::CMD_CLEAR) clr_cmd_r <= 1'b1;
      else if (state_r == S_OUT) clr_cmd_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
    if (in_fire) begin
      cmd_r <= in_cmd;
      unit_ok_r <= (32'(in_tree_state) < NUM_STATES) && (32'(in_unit_type) < NUM_UNIT_TYPES);
      act_ok_r <= (32'(in_action) < NUM_ACTIONS);
      u_r <= UW'(32'(in_tree_state) * NUM_UNIT_TYPES + 32'(in_unit_type));
      a_r <= AW'(in_action);
      v_r <= in_sample_value;
      mask_r <= in_valid_mask;
      k_r <= '0;
      it_r <= '0;
      frac_r <= '0;
      slot_r <= '0;
      found_r <= 1'b0;
      best_r <= '0;
      two_ln_r <= '0;
    end
    case (state_r)
      S_MULA: num_r <= $signed(mean_q) * $signed({1'b0, vis_q}) + v_r;
      S_MULB: ;
      S_LOGA: begin
        if (!(k_r == 5'd31 || (unit_q >> (k_r + 5'd1)) == 32'd0)) k_r <= k_r + 5'd1;
        else m_r <= (k_r == 5'd31) ? (unit_q >> 1) : (unit_q << (5'd30 - k_r));
      end
      S_LOGB: if (it_r != 5'd16) begin
        if (sq_full[61]) begin
          m_r <= sq_full[62:31];
          frac_r[4'd15 - it_r[3:0]] <= 1'b1;
        end else m_r <= sq_full[61:30];
        it_r <= it_r + 5'd1;
      end
      S_LN:  two_ln_r <= {ln_prod[48:16], 1'b0};
      S_SL:  if (slot_r != SLOTS[4:0] && !mask_r[slot_r[3:0]]) slot_r <= slot_r + 5'd1;
      S_SEV: score_r <= ucb1_pkg::UNTRIED_SCORE;
      S_SDIV: if (div_done) begin
        x_r <= div_q;
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      S_SQ: if (bit_r != 64'd0) begin
        if (bit_r > x_r && res_r == 64'd0) ;
        else if (x_r >= sq_sum) begin
          x_r <= x_r - sq_sum;
          res_r <= (res_r >> 1) + bit_r;
        end else res_r <= res_r >> 1;
        bit_r <= bit_r >> 2;
      end
      S_TERM: score_r <= 64'(signed'(mean_q)) + 64'({24'd0, term_prod[47:8]});
      S_CMP: begin
        if (!found_r || score_r > best_score_r) begin
          found_r <= 1'b1;
          best_r <= slot_r[3:0];
          best_score_r <= score_r;
        end
        slot_r <= slot_r + 5'd1;
      end
      S_OUT: if (out_load) begin
        sel_r <= (cmd_r == ucb1_pkg::CMD_SELECT && unit_ok_r && found_r) ? best_r : 4'd0;
        any_r <= cmd_r == ucb1_pkg::CMD_SELECT && unit_ok_r && found_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_selected_action = sel_r;
  assign out_any_valid = any_r;

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(sel_r) && $stable(any_r)))
    else $error("stalled result changed");
  // The divider only finishes while the block waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_UPW || state_r == S_SDIV))
    else $error("divider finished outside a wait state");
  // A result without a valid slot always reports slot zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_any_valid) |-> out_selected_action == 4'd0)
    else $error("nonzero slot without any_valid");
endmodule

FILE: rtl/core/ucb1_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the select radicand and the running-mean update. No dependencies.
module ucb1_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [24:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [24:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [25:0] trial;

  // One shift-and-subtract step per cycle.
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, q_r[63]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 25'(trial - {1'b0, d_r});
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[24:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule
